@@ sv/wplj_pkg.sv @@
// Shared types, register codes and constants for the pair derivative core.
`default_nettype none

package wplj_pkg;

	// default fraction bits of the Q formats
	localparam int FRAC_BITS_DEF = 16;

	// field widths
	localparam int POS_W     = 32;
	localparam int BOX_W     = 31;
	localparam int RAD_W     = 20;
	localparam int CUT_W     = 31;
	localparam int CFG_W     = 31;
	localparam int REG_IDX_W = 3;
	localparam int RES_W     = 64;
	localparam int SQ_W      = 64;

	// 2*radius and its square, Q32 shift of the first quotient
	localparam int A_W    = RAD_W + 1;
	localparam int AA_W   = 2 * A_W;
	localparam int QF     = 32;
	localparam int DIV1_N = AA_W + QF;

	// 12*epsilon
	localparam int LJ_SCALE = 12;
	localparam int EPS12_W  = RAD_W + 4;

	localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
	localparam logic [RES_W-1:0] ONE_Q32 = RES_W'(64'h1_0000_0000);

	// configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_BOX_X   = 3'd0,
		REG_BOX_Y   = 3'd1,
		REG_BOX_Z   = 3'd2,
		REG_RADIUS  = 3'd3,
		REG_EPSILON = 3'd4,
		REG_CUTOFF  = 3'd5
	} reg_idx_t;

	// outcome class decided by the geometry front end
	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_MAX,
		KIND_CALC
	} kind_t;

	// sideband words riding along the arithmetic units
	typedef struct packed {
		kind_t            kind;
		logic [RES_W-1:0] q;
		logic             psat;
	} side_q_t;

	typedef struct packed {
		kind_t kind;
		logic  psat;
	} side_p_t;

	typedef struct packed {
		kind_t            kind;
		logic [RES_W-1:0] p;
	} side_sq_t;

	typedef struct packed {
		logic psat;
		logic neg;
		logic ract;
	} side_h_t;

	typedef struct packed {
		kind_t            kind;
		logic [RES_W-1:0] eps;
		logic             eflag;
		logic             neg;
		logic             ract;
		logic             rsat;
	} side_r_t;

endpackage

`default_nettype wire

@@ sv/wplj_geom.sv @@
// Geometry front end: minimum-image wrap, squared distance, cutoff and class.
`default_nettype none

module wplj_geom import wplj_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic signed [POS_W-1:0] first_x,
	input  wire logic signed [POS_W-1:0] first_y,
	input  wire logic signed [POS_W-1:0] first_z,
	input  wire logic signed [POS_W-1:0] second_x,
	input  wire logic signed [POS_W-1:0] second_y,
	input  wire logic signed [POS_W-1:0] second_z,
	input  wire logic                    self_pair,
	input  wire logic [BOX_W-1:0]        box_x,
	input  wire logic [BOX_W-1:0]        box_y,
	input  wire logic [BOX_W-1:0]        box_z,
	input  wire logic [CUT_W-1:0]        cutoff,
	input  wire logic                    radius_nz,
	output logic                         out_valid,
	output logic [SQ_W-1:0]              dist_sq,
	output kind_t                        kind
);

	logic signed [POS_W-1:0] pa [3];
	logic signed [POS_W-1:0] pb [3];
	logic [BOX_W-1:0]        bx [3];

	logic signed [POS_W:0]   d_s1 [3];
	logic signed [POS_W+2:0] w_s2 [3];
	logic [CUT_W-1:0]        mag_s3 [3];
	logic [2*CUT_W-1:0]      sq_s4 [3];
	logic [SQ_W-1:0]         s_s5;
	logic [SQ_W-1:0]         s_s6;
	kind_t                   kind_s6;

	logic                    self_s1, self_s2, self_s3, self_s4, self_s5;
	logic                    in_s3, in_s4, in_s5;
	logic                    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [2*CUT_W-1:0]      cc_q;

	logic signed [POS_W:0]   d_c [3];
	logic signed [POS_W+2:0] w_c [3];
	logic [POS_W+2:0]        m_c [3];
	logic [2:0]              lt_c;
	kind_t                   kind_c;

	assign pa[0] = first_x;
	assign pa[1] = first_y;
	assign pa[2] = first_z;
	assign pb[0] = second_x;
	assign pb[1] = second_y;
	assign pb[2] = second_z;
	assign bx[0] = box_x;
	assign bx[1] = box_y;
	assign bx[2] = box_z;

	// per-axis difference, wrap and magnitude
	always_comb begin
		logic signed [POS_W+2:0] dw;
		logic signed [POS_W+2:0] tw;
		logic signed [POS_W+2:0] bs;
		for (int k = 0; k < 3; k++) begin
			d_c[k] = (POS_W+1)'(pa[k]) - (POS_W+1)'(pb[k]);
			dw = (POS_W+3)'(d_s1[k]);
			tw = dw <<< 1;
			bs = $signed({4'b0, bx[k]});
			if (tw <= -bs) begin
				w_c[k] = dw + bs;
			end else if (tw > bs) begin
				w_c[k] = dw - bs;
			end else begin
				w_c[k] = dw;
			end
			m_c[k] = w_s2[k][POS_W+2] ? (POS_W+3)'(-w_s2[k]) : (POS_W+3)'(w_s2[k]);
			lt_c[k] = m_c[k] < {4'b0, cutoff};
		end
	end

	// classify the pair
	always_comb begin
		if (self_s5 || !in_s5 || s_s5 >= {2'b0, cc_q}) begin
			kind_c = KIND_ZERO;
		end else if (s_s5 == '0) begin
			kind_c = KIND_MAX;
		end else if (!radius_nz) begin
			kind_c = KIND_ZERO;
		end else begin
			kind_c = KIND_CALC;
		end
	end

	// valid bits and cutoff square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			cc_q <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			cc_q <= (2*CUT_W)'(cutoff) * (2*CUT_W)'(cutoff);
		end
	end

	// data path
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			d_s1[k]   <= d_c[k];
			w_s2[k]   <= w_c[k];
			mag_s3[k] <= m_c[k][CUT_W-1:0];
			sq_s4[k]  <= (2*CUT_W)'(mag_s3[k]) * (2*CUT_W)'(mag_s3[k]);
		end
		self_s1 <= self_pair;
		self_s2 <= self_s1;
		self_s3 <= self_s2;
		self_s4 <= self_s3;
		self_s5 <= self_s4;
		in_s3   <= &lt_c;
		in_s4   <= in_s3;
		in_s5   <= in_s4;
		s_s5    <= SQ_W'(sq_s4[0]) + SQ_W'(sq_s4[1]) + SQ_W'(sq_s4[2]);
		s_s6    <= s_s5;
		kind_s6 <= kind_c;
	end

	assign out_valid = v_s6;
	assign dist_sq   = s_s6;
	assign kind      = kind_s6;

	// a self pair never leaves as a computed or clamped pair
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && self_s5 |=> kind_s6 == KIND_ZERO)
		else $error("self pair not forced to zero");

endmodule

`default_nettype wire

@@ sv/wplj_mul.sv @@
// Pipelined 64x64 multiply with a constant right shift and saturation flag.
`default_nettype none

module wplj_mul import wplj_pkg::*; #(
	parameter int SH = 32,
	parameter int SW = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [RES_W-1:0] x,
	input  wire logic [RES_W-1:0] y,
	input  wire logic [SW-1:0]    side_in,
	output logic                  out_valid,
	output logic [RES_W-1:0]      prod,
	output logic                  sat,
	output logic [SW-1:0]         side_out
);

	localparam int HW = RES_W / 2;

	logic [RES_W-1:0]   p00_s1, p01_s1, p10_s1, p11_s1;
	logic [HW+1:0]      mid_s2;
	logic [RES_W-1:0]   hi_s2;
	logic [HW-1:0]      lo_s2;
	logic [RES_W-1:0]   res_s3;
	logic               sat_s3;
	logic [SW-1:0]      sd_s1, sd_s2, sd_s3;
	logic               v_s1, v_s2, v_s3;

	logic [RES_W-1:0]   hi_c;
	logic [2*RES_W-1:0] full_c;

	// final carry into the high word, then shift and overflow test
	assign hi_c   = hi_s2 + RES_W'(mid_s2[HW+1:HW]);
	assign full_c = {hi_c, mid_s2[HW-1:0], lo_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// partial products, column sums, result
	always_ff @(posedge clk) begin
		p00_s1 <= RES_W'(x[HW-1:0])     * RES_W'(y[HW-1:0]);
		p01_s1 <= RES_W'(x[HW-1:0])     * RES_W'(y[RES_W-1:HW]);
		p10_s1 <= RES_W'(x[RES_W-1:HW]) * RES_W'(y[HW-1:0]);
		p11_s1 <= RES_W'(x[RES_W-1:HW]) * RES_W'(y[RES_W-1:HW]);
		sd_s1  <= side_in;
		mid_s2 <= (HW+2)'(p00_s1[RES_W-1:HW]) + (HW+2)'(p01_s1[HW-1:0])
			+ (HW+2)'(p10_s1[HW-1:0]);
		hi_s2  <= p11_s1 + RES_W'(p01_s1[RES_W-1:HW]) + RES_W'(p10_s1[RES_W-1:HW]);
		lo_s2  <= p00_s1[HW-1:0];
		sd_s2  <= sd_s1;
		res_s3 <= full_c[RES_W-1+SH:SH];
		sat_s3 <= |full_c[2*RES_W-1:RES_W+SH];
		sd_s3  <= sd_s2;
	end

	assign out_valid = v_s3;
	assign prod      = res_s3;
	assign sat       = sat_s3;
	assign side_out  = sd_s3;

	// the result valid follows the operand valid through the s1, s2 and s3 registers
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 == $past(in_valid, 3))
		else $error("multiplier latency broken");

endmodule

`default_nettype wire

@@ sv/wplj_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none

module wplj_div import wplj_pkg::*; #(
	parameter int N  = 74,
	parameter int D  = 64,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [N-1:0]  num,
	input  wire logic [D-1:0]  den,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [N-1:0]       quo,
	output logic [SW-1:0]      side_out
);

	// upper D bits hold the partial remainder, lower N the dividend/quotient
	logic [D+N-1:0] wk_s [1:N];
	logic [D-1:0]   dn_s [1:N];
	logic [SW-1:0]  sd_s [1:N];
	logic           v_s  [1:N];

	for (genvar i = 1; i <= N; i++) begin : g_stage
		logic [D+N-1:0] w_in;
		logic [D-1:0]   d_in;
		logic [SW-1:0]  s_in;
		logic           v_in;
		logic [D:0]     t;
		logic [D:0]     diff;
		logic           ge;

		if (i == 1) begin : g_first
			assign w_in = {{D{1'b0}}, num};
			assign d_in = den;
			assign s_in = side_in;
			assign v_in = in_valid;
		end else begin : g_rest
			assign w_in = wk_s[i-1];
			assign d_in = dn_s[i-1];
			assign s_in = sd_s[i-1];
			assign v_in = v_s[i-1];
		end

		// shift in one dividend bit, subtract when it fits
		assign t    = {w_in[D+N-1:N], w_in[N-1]};
		assign diff = t - {1'b0, d_in};
		assign ge   = t >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			wk_s[i] <= {(ge ? diff[D-1:0] : t[D-1:0]), w_in[N-2:0], ge};
			dn_s[i] <= d_in;
			sd_s[i] <= s_in;
		end
	end

	assign out_valid = v_s[N];
	assign quo       = wk_s[N][N-1:0];
	assign side_out  = sd_s[N];

	// the last stage takes the valid bit of the stage before it in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N] == $past(v_s[N-1]))
		else $error("divider latency broken");

endmodule

`default_nettype wire

@@ sv/water_pair_lj_derivative_core.sv @@
// Top level: Lennard-Jones radius and epsilon derivatives for one particle pair.
//
//  channel   signals                                  direction  handshake
//  pair in   first_*, second_*, self_pair             in         start & !busy
//  config    wr_en, wr_index, wr_data                 in         wr_en
//  result    radius_derivative, epsilon_derivative,   out        done, one cycle
//            saturated
//
// One pair word is taken every cycle; busy stays low.
// The two dividers are bit-per-stage: 74 stages for the squared ratio,
// 64 + FRAC_BITS for the radius term.
// arst_n clears all valid bits and the configuration registers to zero.
// The receiver cannot stall; each result is shown on done for exactly one cycle.
`default_nettype none

module water_pair_lj_derivative_core import wplj_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic signed [POS_W-1:0]  first_x,
	input  wire logic signed [POS_W-1:0]  first_y,
	input  wire logic signed [POS_W-1:0]  first_z,
	input  wire logic signed [POS_W-1:0]  second_x,
	input  wire logic signed [POS_W-1:0]  second_y,
	input  wire logic signed [POS_W-1:0]  second_z,
	input  wire logic                     self_pair,
	input  wire logic                     wr_en,
	input  wire logic [REG_IDX_W-1:0]     wr_index,
	input  wire logic [CFG_W-1:0]         wr_data,
	output logic                          done,
	output logic signed [RES_W-1:0]       radius_derivative,
	output logic signed [RES_W-1:0]       epsilon_derivative,
	output logic                          saturated
);

	localparam int DIV2_N = RES_W + FRAC_BITS;

	// configuration and derived constants
	logic [BOX_W-1:0]   box_x_q, box_y_q, box_z_q;
	logic [RAD_W-1:0]   radius_q, eps_q;
	logic [CUT_W-1:0]   cutoff_q;
	logic [A_W-1:0]     a_q;
	logic [AA_W-1:0]    aa_q;
	logic [EPS12_W-1:0] eps12_q;
	logic               rnz_q, enz_q;
	logic [2*RAD_W-1:0] r2_c;

	// geometry
	logic               g_valid;
	logic [SQ_W-1:0]    g_s;
	kind_t              g_kind;

	// ratio a^2/s and its powers
	logic               d1_valid;
	logic [DIV1_N-1:0]  d1_quo;
	logic [$bits(kind_t)-1:0] d1_kind;
	side_q_t            ma_side_in, ma_side;
	logic               ma_valid, ma_sat;
	logic [RES_W-1:0]   ma_prod;
	side_p_t            mb_side_in, mb_side;
	logic               mb_valid, mb_sat;
	logic [RES_W-1:0]   mb_prod;

	// p6 stage
	logic [RES_W-1:0]   p_c, g_c;
	logic               psat_c;
	logic [RES_W-1:0]   p_s1, g_s1;
	logic               psat_s1, neg_s1, ract_s1, v_s1;
	kind_t              kind_s1;

	// p6^2 / 2 and p6 * |p6 - 1|
	side_sq_t           mc_side;
	side_h_t            md_side;
	logic               mc_valid, mc_sat, md_valid, md_sat;
	logic [RES_W-1:0]   mc_prod, md_prod;

	// epsilon term
	logic               esat_s2, ege_s2, rsat_s2, neg_s2, ract_s2, v_s2;
	logic [RES_W-1:0]   ediff_s2, h_s2;
	kind_t              kind_s2;
	logic [RES_W-1:0]   eps_c;
	logic               eflag_c;
	logic [RES_W-1:0]   eps_s3, h_s3;
	logic               eflag_s3, rsat_s3, neg_s3, ract_s3, v_s3;
	kind_t              kind_s3;

	// radius term
	side_r_t            me_side_in, me_side;
	logic               me_valid, me_sat;
	logic [RES_W-1:0]   me_prod;
	side_r_t            side_s4;
	logic [RES_W-1:0]   m_s4;
	logic               v_s4;
	logic               d2_valid;
	logic [DIV2_N-1:0]  d2_quo;
	side_r_t            d2_side;

	// result
	logic [RES_W-1:0]   mq_c, rad_c, rout_c, eout_c;
	logic               msat_c, rflag_c, sout_c;
	logic [RES_W-1:0]   rad_s5, eps_s5;
	logic               sat_s5, v_s5;

	assign busy = 1'b0;
	assign r2_c = (2*RAD_W)'(radius_q) * (2*RAD_W)'(radius_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q  <= '0;
			box_y_q  <= '0;
			box_z_q  <= '0;
			radius_q <= '0;
			eps_q    <= '0;
			cutoff_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BOX_X:   box_x_q  <= wr_data;
				REG_BOX_Y:   box_y_q  <= wr_data;
				REG_BOX_Z:   box_z_q  <= wr_data;
				REG_RADIUS:  radius_q <= wr_data[RAD_W-1:0];
				REG_EPSILON: eps_q    <= wr_data[RAD_W-1:0];
				REG_CUTOFF:  cutoff_q <= wr_data;
				default:     ;
			endcase
		end
	end

	// constants derived from the configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= '0;
			aa_q    <= '0;
			eps12_q <= '0;
			rnz_q   <= 1'b0;
			enz_q   <= 1'b0;
		end else begin
			a_q     <= {radius_q, 1'b0};
			aa_q    <= {r2_c, 2'b0};
			eps12_q <= EPS12_W'(eps_q) * EPS12_W'(LJ_SCALE);
			rnz_q   <= radius_q != '0;
			enz_q   <= eps_q != '0;
		end
	end

	wplj_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.first_x   (first_x),
		.first_y   (first_y),
		.first_z   (first_z),
		.second_x  (second_x),
		.second_y  (second_y),
		.second_z  (second_z),
		.self_pair (self_pair),
		.box_x     (box_x_q),
		.box_y     (box_y_q),
		.box_z     (box_z_q),
		.cutoff    (cutoff_q),
		.radius_nz (rnz_q),
		.out_valid (g_valid),
		.dist_sq   (g_s),
		.kind      (g_kind)
	);

	// q = a^2 * 2^32 / s
	wplj_div #(.N(DIV1_N), .D(SQ_W), .SW($bits(kind_t))) u_div_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (g_valid),
		.num       ({aa_q, {QF{1'b0}}}),
		.den       (g_s),
		.side_in   (g_kind),
		.out_valid (d1_valid),
		.quo       (d1_quo),
		.side_out  (d1_kind)
	);

	assign ma_side_in = '{kind: kind_t'(d1_kind), q: d1_quo[RES_W-1:0],
		psat: |d1_quo[DIV1_N-1:RES_W]};

	// q^2
	wplj_mul #(.SH(QF), .SW($bits(side_q_t))) u_mul_q2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_valid),
		.x         (d1_quo[RES_W-1:0]),
		.y         (d1_quo[RES_W-1:0]),
		.side_in   (ma_side_in),
		.out_valid (ma_valid),
		.prod      (ma_prod),
		.sat       (ma_sat),
		.side_out  (ma_side)
	);

	assign mb_side_in = '{kind: ma_side.kind, psat: ma_side.psat | ma_sat};

	// p6 = q^3
	wplj_mul #(.SH(QF), .SW($bits(side_p_t))) u_mul_p6 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ma_valid),
		.x         (ma_prod),
		.y         (ma_side.q),
		.side_in   (mb_side_in),
		.out_valid (mb_valid),
		.prod      (mb_prod),
		.sat       (mb_sat),
		.side_out  (mb_side)
	);

	// p6 clamp and |p6 - 1|
	assign psat_c = mb_side.psat | mb_sat;
	assign p_c    = psat_c ? '1 : mb_prod;
	assign g_c    = (p_c >= ONE_Q32) ? p_c - ONE_Q32 : ONE_Q32 - p_c;

	always_ff @(posedge clk) begin
		p_s1    <= p_c;
		g_s1    <= g_c;
		psat_s1 <= psat_c;
		neg_s1  <= p_c < ONE_Q32;
		ract_s1 <= (p_c != '0) && (p_c != ONE_Q32) && enz_q;
		kind_s1 <= mb_side.kind;
	end

	// p6^2 / 2
	wplj_mul #(.SH(QF+1), .SW($bits(side_sq_t))) u_mul_pp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.x         (p_s1),
		.y         (p_s1),
		.side_in   ({kind_s1, p_s1}),
		.out_valid (mc_valid),
		.prod      (mc_prod),
		.sat       (mc_sat),
		.side_out  (mc_side)
	);

	// p6 * |p6 - 1|
	wplj_mul #(.SH(QF), .SW($bits(side_h_t))) u_mul_pg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.x         (p_s1),
		.y         (g_s1),
		.side_in   ({psat_s1, neg_s1, ract_s1}),
		.out_valid (md_valid),
		.prod      (md_prod),
		.sat       (md_sat),
		.side_out  (md_side)
	);

	// epsilon difference
	always_ff @(posedge clk) begin
		esat_s2  <= md_side.psat | mc_sat;
		ege_s2   <= mc_prod >= mc_side.p;
		ediff_s2 <= (mc_prod >= mc_side.p) ? mc_prod - mc_side.p : mc_side.p - mc_prod;
		h_s2     <= md_prod;
		rsat_s2  <= md_side.psat | md_sat;
		neg_s2   <= md_side.neg;
		ract_s2  <= md_side.ract;
		kind_s2  <= mc_side.kind;
	end

	// epsilon signed clamp
	always_comb begin
		eflag_c = 1'b0;
		if (esat_s2) begin
			eps_c   = RES_MAX;
			eflag_c = 1'b1;
		end else if (ege_s2) begin
			if (ediff_s2 > RES_MAX) begin
				eps_c   = RES_MAX;
				eflag_c = 1'b1;
			end else begin
				eps_c = ediff_s2;
			end
		end else if (ediff_s2 > RES_MIN) begin
			eps_c   = RES_MIN;
			eflag_c = 1'b1;
		end else begin
			eps_c = '0 - ediff_s2;
		end
	end

	always_ff @(posedge clk) begin
		eps_s3   <= eps_c;
		eflag_s3 <= eflag_c;
		h_s3     <= h_s2;
		rsat_s3  <= rsat_s2;
		neg_s3   <= neg_s2;
		ract_s3  <= ract_s2;
		kind_s3  <= kind_s2;
	end

	assign me_side_in = '{kind: kind_s3, eps: eps_s3, eflag: eflag_s3, neg: neg_s3,
		ract: ract_s3, rsat: rsat_s3};

	// h * 12 * epsilon
	wplj_mul #(.SH(FRAC_BITS), .SW($bits(side_r_t))) u_mul_eps (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.x         (h_s3),
		.y         (RES_W'(eps12_q)),
		.side_in   (me_side_in),
		.out_valid (me_valid),
		.prod      (me_prod),
		.sat       (me_sat),
		.side_out  (me_side)
	);

	always_ff @(posedge clk) begin
		m_s4    <= me_prod;
		side_s4 <= '{kind: me_side.kind, eps: me_side.eps, eflag: me_side.eflag,
			neg: me_side.neg, ract: me_side.ract, rsat: me_side.rsat | me_sat};
	end

	// m * 2^F / a
	wplj_div #(.N(DIV2_N), .D(A_W), .SW($bits(side_r_t))) u_div_rad (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.num       ({m_s4, {FRAC_BITS{1'b0}}}),
		.den       (a_q),
		.side_in   (side_s4),
		.out_valid (d2_valid),
		.quo       (d2_quo),
		.side_out  (d2_side)
	);

	// radius clamp and final selection by class
	assign mq_c   = d2_quo[RES_W-1:0];
	assign msat_c = d2_side.rsat | (|d2_quo[DIV2_N-1:RES_W]);

	always_comb begin
		rflag_c = 1'b0;
		if (!d2_side.ract) begin
			rad_c = '0;
		end else if (msat_c) begin
			rad_c   = d2_side.neg ? RES_MIN : RES_MAX;
			rflag_c = 1'b1;
		end else if (d2_side.neg) begin
			if (mq_c > RES_MIN) begin
				rad_c   = RES_MIN;
				rflag_c = 1'b1;
			end else begin
				rad_c = '0 - mq_c;
			end
		end else if (mq_c > RES_MAX) begin
			rad_c   = RES_MAX;
			rflag_c = 1'b1;
		end else begin
			rad_c = mq_c;
		end

		case (d2_side.kind)
			KIND_CALC: begin
				rout_c = rad_c;
				eout_c = d2_side.eps;
				sout_c = d2_side.eflag | rflag_c;
			end
			KIND_MAX: begin
				rout_c = RES_MAX;
				eout_c = RES_MAX;
				sout_c = 1'b1;
			end
			default: begin
				rout_c = '0;
				eout_c = '0;
				sout_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rad_s5 <= rout_c;
		eps_s5 <= eout_c;
		sat_s5 <= sout_c;
	end

	// valid bits of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= mb_valid;
			v_s2 <= mc_valid && md_valid;
			v_s3 <= v_s2;
			v_s4 <= me_valid;
			v_s5 <= d2_valid;
		end
	end

	assign done               = v_s5;
	assign radius_derivative  = rad_s5;
	assign epsilon_derivative = eps_s5;
	assign saturated          = sat_s5;

	// a flagged word carries at least one clamped value
	assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> radius_derivative == RES_MAX ||
			radius_derivative == RES_MIN || epsilon_derivative == RES_MAX ||
			epsilon_derivative == RES_MIN)
		else $error("saturated without a clamped result");

	// p6*(p6/2 - 1) never drops below -0.5
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> epsilon_derivative >= -64'sd2147483648)
		else $error("epsilon derivative below its floor");

endmodule

`default_nettype wire
